@@ design/rrss_pkg.sv @@
// Shared constants, payload types and state encoding of the round-robin sleep scheduler.
package rrss_pkg;

	localparam int MAX_THREADS  = 32;
	localparam int SLOT_W       = $clog2(MAX_THREADS);
	localparam int CNT_W        = $clog2(MAX_THREADS + 1);
	localparam int OP_W         = 3;
	localparam int TICKS_W      = 32;
	localparam int SLOT_FIELD_W = 5;

	localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
	localparam logic [OP_W-1:0] OP_KILL  = 3'd1;
	localparam logic [OP_W-1:0] OP_SLEEP = 3'd2;
	localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
	localparam logic [OP_W-1:0] OP_SCHED = 3'd4;

	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [TICKS_W-1:0] sleep_ticks;
	} req_t;

	typedef struct packed {
		logic                    ok;
		logic [SLOT_FIELD_W-1:0] slot;
		logic                    none_ready;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ADD_SCAN,
		ST_ADD_LINK0,
		ST_ADD_LINK1,
		ST_KILL_WR,
		ST_TICK,
		ST_SCHED_FIRST,
		ST_SCHED_WALK,
		ST_DONE
	} state_t;

	function automatic logic [SLOT_FIELD_W-1:0] slot_field(slot_idx_t v);
		logic [SLOT_W+SLOT_FIELD_W-1:0] w;
		w = {{SLOT_FIELD_W{1'b0}}, v};
		return w[SLOT_FIELD_W-1:0];
	endfunction

endpackage

@@ design/rrss_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module rrss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/round_robin_sleep_scheduler.sv @@
// Top level of the round-robin sleep scheduler: sequencer, ring pointers, link and count memories.
//
// channel  direction  handshake               payload
// req      in         req_valid / req_stall   rrss_pkg::req_t (op, sleep_ticks)
// rsp      out        rsp_valid / rsp_stall   rrss_pkg::rsp_t (ok, slot, none_ready)
//
// One request is worked at a time; req_stall is high from acceptance until the result is loaded.
// Add scans one slot a cycle for a free slot, then links it in. Kill relinks the neighbours; sleep writes its count.
// Tick sweeps every slot through the count memory.
// Schedule walks the ring one slot a cycle.
// Each link and count memory has a single read port.
// A result waits in the output register under rsp_stall while the next request is worked.
module round_robin_sleep_scheduler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rrss_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rrss_pkg::rsp_t rsp
);

	localparam int MAXT = rrss_pkg::MAX_THREADS;
	localparam int SW   = rrss_pkg::SLOT_W;
	localparam int CW   = rrss_pkg::CNT_W;
	localparam int TW   = rrss_pkg::TICKS_W;

	rrss_pkg::state_t state_q, state_d;

	logic [rrss_pkg::OP_W-1:0] op_q;
	logic [TW-1:0]             ticks_q;
	logic [MAXT-1:0]           used_q;
	rrss_pkg::slot_idx_t       head_q, tail_q, run_q, add_slot_q, cur_q;
	rrss_pkg::cnt_t            cnt_q, scan_q, k_q;
	logic                      tick_vld_s1;
	rrss_pkg::slot_idx_t       tick_idx_s1;
	logic                      ok_q, none_q, is_add_q;
	rrss_pkg::rsp_t            rsp_q;
	logic                      rsp_valid_q;

	logic                nx_we, pv_we, sl_we;
	rrss_pkg::slot_idx_t nx_waddr, pv_waddr, sl_waddr;
	rrss_pkg::slot_idx_t nx_wdata, pv_wdata;
	logic [TW-1:0]       sl_wdata;
	rrss_pkg::slot_idx_t nx_raddr, pv_raddr, sl_raddr;
	rrss_pkg::slot_idx_t nx_rdata, pv_rdata;
	logic [TW-1:0]       sl_rdata;

	logic                run_live;
	rrss_pkg::slot_idx_t scan_idx;
	rrss_pkg::slot_idx_t first_c;
	logic                sleep_zero;
	rrss_pkg::cnt_t      k_next;
	logic                walk_end;
	logic                rsp_free;
	rrss_pkg::rsp_t      rsp_d;

	assign run_live   = (cnt_q != '0) && used_q[run_q];
	assign scan_idx   = scan_q[SW-1:0];
	assign first_c    = used_q[nx_rdata] ? nx_rdata : head_q;
	assign sleep_zero = (sl_rdata == '0);
	assign k_next     = k_q + CW'(1);
	assign walk_end   = (k_next >= cnt_q);
	assign rsp_free   = !rsp_valid_q || !rsp_stall;

	always_comb begin
		rsp_d.ok         = ok_q;
		rsp_d.none_ready = none_q;
		if (is_add_q) begin
			rsp_d.slot = ok_q ? rrss_pkg::slot_field(add_slot_q) : '0;
		end else begin
			rsp_d.slot = rrss_pkg::slot_field(run_q);
		end
	end

	rrss_ram #(.WIDTH(SW), .DEPTH(MAXT)) u_next_ram (
		.clk(clk), .wr_en(nx_we), .wr_addr(nx_waddr), .wr_data(nx_wdata),
		.rd_addr(nx_raddr), .rd_data(nx_rdata)
	);

	rrss_ram #(.WIDTH(SW), .DEPTH(MAXT)) u_prev_ram (
		.clk(clk), .wr_en(pv_we), .wr_addr(pv_waddr), .wr_data(pv_wdata),
		.rd_addr(pv_raddr), .rd_data(pv_rdata)
	);

	rrss_ram #(.WIDTH(TW), .DEPTH(MAXT)) u_sleep_ram (
		.clk(clk), .wr_en(sl_we), .wr_addr(sl_waddr), .wr_data(sl_wdata),
		.rd_addr(sl_raddr), .rd_data(sl_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rrss_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = rrss_pkg::ST_DISPATCH;
				end
			end
			rrss_pkg::ST_DISPATCH: begin
				case (op_q)
					rrss_pkg::OP_ADD: state_d = rrss_pkg::ST_ADD_SCAN;
					rrss_pkg::OP_KILL: begin
						state_d = (run_live && cnt_q > CW'(1)) ? rrss_pkg::ST_KILL_WR
							: rrss_pkg::ST_DONE;
					end
					rrss_pkg::OP_TICK: begin
						state_d = (cnt_q != '0) ? rrss_pkg::ST_TICK : rrss_pkg::ST_DONE;
					end
					rrss_pkg::OP_SCHED: begin
						state_d = (cnt_q != '0) ? rrss_pkg::ST_SCHED_FIRST : rrss_pkg::ST_DONE;
					end
					default: state_d = rrss_pkg::ST_DONE;
				endcase
			end
			rrss_pkg::ST_ADD_SCAN: begin
				if (!used_q[scan_idx]) begin
					state_d = rrss_pkg::ST_ADD_LINK0;
				end else if (scan_q == CW'(MAXT - 1)) begin
					state_d = rrss_pkg::ST_DONE;
				end
			end
			rrss_pkg::ST_ADD_LINK0: begin
				state_d = (cnt_q == '0) ? rrss_pkg::ST_DONE : rrss_pkg::ST_ADD_LINK1;
			end
			rrss_pkg::ST_ADD_LINK1: state_d = rrss_pkg::ST_DONE;
			rrss_pkg::ST_KILL_WR: state_d = rrss_pkg::ST_DONE;
			rrss_pkg::ST_TICK: begin
				if (scan_q == CW'(MAXT)) begin
					state_d = rrss_pkg::ST_DONE;
				end
			end
			rrss_pkg::ST_SCHED_FIRST: state_d = rrss_pkg::ST_SCHED_WALK;
			rrss_pkg::ST_SCHED_WALK: begin
				if (sleep_zero || walk_end) begin
					state_d = rrss_pkg::ST_DONE;
				end
			end
			rrss_pkg::ST_DONE: begin
				if (rsp_free) begin
					state_d = rrss_pkg::ST_IDLE;
				end
			end
			default: state_d = rrss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		nx_we     = 1'b0;
		nx_waddr  = '0;
		nx_wdata  = '0;
		nx_raddr  = '0;
		pv_we     = 1'b0;
		pv_waddr  = '0;
		pv_wdata  = '0;
		pv_raddr  = '0;
		sl_we     = 1'b0;
		sl_waddr  = '0;
		sl_wdata  = '0;
		sl_raddr  = '0;
		case (state_q)
			rrss_pkg::ST_IDLE: req_stall = 1'b0;
			rrss_pkg::ST_DISPATCH: begin
				nx_raddr = run_q;
				pv_raddr = run_q;
				if (op_q == rrss_pkg::OP_SLEEP && run_live) begin
					sl_we    = 1'b1;
					sl_waddr = run_q;
					sl_wdata = ticks_q;
				end
			end
			rrss_pkg::ST_ADD_LINK0: begin
				nx_we    = 1'b1;
				nx_waddr = add_slot_q;
				nx_wdata = (cnt_q == '0) ? add_slot_q : head_q;
				pv_we    = 1'b1;
				pv_waddr = add_slot_q;
				pv_wdata = (cnt_q == '0) ? add_slot_q : tail_q;
				sl_we    = 1'b1;
				sl_waddr = add_slot_q;
				sl_wdata = '0;
			end
			rrss_pkg::ST_ADD_LINK1: begin
				pv_we    = 1'b1;
				pv_waddr = head_q;
				pv_wdata = add_slot_q;
				nx_we    = 1'b1;
				nx_waddr = tail_q;
				nx_wdata = add_slot_q;
			end
			rrss_pkg::ST_KILL_WR: begin
				pv_we    = 1'b1;
				pv_waddr = nx_rdata;
				pv_wdata = pv_rdata;
				nx_we    = 1'b1;
				nx_waddr = pv_rdata;
				nx_wdata = nx_rdata;
			end
			rrss_pkg::ST_TICK: begin
				sl_raddr = scan_idx;
				sl_we    = tick_vld_s1 && used_q[tick_idx_s1] && !sleep_zero;
				sl_waddr = tick_idx_s1;
				sl_wdata = sl_rdata - TW'(1);
			end
			rrss_pkg::ST_SCHED_FIRST: begin
				nx_raddr = first_c;
				sl_raddr = first_c;
			end
			rrss_pkg::ST_SCHED_WALK: begin
				nx_raddr = nx_rdata;
				sl_raddr = nx_rdata;
			end
			default: req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			run_q       <= '0;
			cnt_q       <= '0;
			tick_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			tick_vld_s1 <= (state_q == rrss_pkg::ST_TICK) && (scan_q != CW'(MAXT));
			if (state_q == rrss_pkg::ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				rrss_pkg::ST_DISPATCH: begin
					if (op_q == rrss_pkg::OP_KILL && run_live && cnt_q == CW'(1)) begin
						cnt_q         <= '0;
						used_q[run_q] <= 1'b0;
					end
				end
				rrss_pkg::ST_ADD_LINK0: begin
					used_q[add_slot_q] <= 1'b1;
					cnt_q              <= cnt_q + CW'(1);
					if (cnt_q == '0) begin
						head_q <= add_slot_q;
						tail_q <= add_slot_q;
						run_q  <= add_slot_q;
					end
				end
				rrss_pkg::ST_ADD_LINK1: tail_q <= add_slot_q;
				rrss_pkg::ST_KILL_WR: begin
					cnt_q         <= cnt_q - CW'(1);
					used_q[run_q] <= 1'b0;
					if (run_q == tail_q) begin
						tail_q <= pv_rdata;
					end
					if (run_q == head_q) begin
						head_q <= nx_rdata;
					end
				end
				rrss_pkg::ST_SCHED_WALK: begin
					if (sleep_zero) begin
						run_q <= cur_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rrss_pkg::ST_DONE && rsp_free) begin
			rsp_q <= rsp_d;
		end
		case (state_q)
			rrss_pkg::ST_IDLE: begin
				if (req_valid) begin
					op_q    <= req.op;
					ticks_q <= req.sleep_ticks;
				end
			end
			rrss_pkg::ST_DISPATCH: begin
				none_q   <= 1'b0;
				is_add_q <= (op_q == rrss_pkg::OP_ADD);
				scan_q   <= '0;
				case (op_q)
					rrss_pkg::OP_KILL:  ok_q <= run_live;
					rrss_pkg::OP_SLEEP: ok_q <= run_live;
					rrss_pkg::OP_TICK:  ok_q <= (cnt_q != '0);
					default:            ok_q <= 1'b0;
				endcase
			end
			rrss_pkg::ST_ADD_SCAN: begin
				if (!used_q[scan_idx]) begin
					add_slot_q <= scan_idx;
				end else begin
					scan_q <= scan_q + CW'(1);
				end
			end
			rrss_pkg::ST_ADD_LINK0: ok_q <= 1'b1;
			rrss_pkg::ST_TICK: begin
				tick_idx_s1 <= scan_idx;
				if (scan_q != CW'(MAXT)) begin
					scan_q <= scan_q + CW'(1);
				end
			end
			rrss_pkg::ST_SCHED_FIRST: begin
				cur_q <= first_c;
				k_q   <= '0;
			end
			rrss_pkg::ST_SCHED_WALK: begin
				if (sleep_zero) begin
					ok_q <= 1'b1;
				end else if (walk_end) begin
					none_q <= 1'b1;
				end else begin
					k_q   <= k_next;
					cur_q <= nx_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rrss_pkg::ST_IDLE |-> $countones(used_q) == int'(cnt_q))
		else $error("Thread count does not match the number of used slots.");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= MAXT)
		else $error("Thread count exceeds the pool size.");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == rrss_pkg::ST_DONE))
		else $error("A result was loaded outside the completion state.");

	a_sched_picks_walk_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rrss_pkg::ST_SCHED_WALK && sleep_zero |=> run_q == $past(cur_q))
		else $error("Schedule did not move to the ready slot it found.");

	a_tick_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rrss_pkg::ST_TICK && sl_we |-> sl_waddr != sl_raddr
			|| scan_q == CW'(MAXT))
		else $error("Tick sweep wrote the entry it is reading.");

	a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!req_stall |-> state_q == rrss_pkg::ST_IDLE && $countones(used_q) == int'(cnt_q))
		else $error("A request was taken while another was in progress.");

endmodule
